>>> rtl/i2d_pkg.sv
// shared types and constants for the int64 to binary64 converter
`default_nettype none
package i2d_pkg;
  localparam int LANES = 4;
  localparam int FRAC_BITS = 52;
  localparam logic [10:0] EXP_BIAS = 11'd1023;
  localparam logic KIND_SIGNED = 1'b0;

  typedef logic [63:0] word_t;
  typedef word_t [LANES-1:0] lanes_t;

  typedef struct packed {
    logic kind;
    lanes_t values;
  } in_item_t;

  typedef struct packed {
    lanes_t doubles;
  } out_item_t;

  // stage 1 result: sign and magnitude
  typedef struct packed {
    logic sign;
    logic [63:0] mag;
  } sm_t;

  // stage 2 result: normalized magnitude with leading one at bit 63
  typedef struct packed {
    logic sign;
    logic zero;
    logic [5:0] msb;
    logic [63:0] norm;
  } nm_t;
endpackage
`default_nettype wire

>>> rtl/i2d_if.sv
// valid/ready channel interface carrying one item
`default_nettype none
interface i2d_if #(parameter type item_t = logic) ();
  logic valid;
  logic ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/i2d_lane.sv
// one lane: three registered steps (magnitude, normalize, round and pack)
`default_nettype none
module i2d_lane import i2d_pkg::*; (
  input  wire logic        clk,
  input  wire logic [2:0]  en,
  input  wire logic        is_signed,
  input  wire logic [63:0] raw,
  output logic [63:0]      result
);
  sm_t sm_r, sm_nxt;
  nm_t nm_r, nm_nxt;
  logic [63:0] res_r, res_nxt;

  always_comb begin
    sm_nxt.sign = is_signed & raw[63];
    sm_nxt.mag  = sm_nxt.sign ? (~raw + 64'd1) : raw;
  end

  always_comb begin
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (sm_r.mag[i]) p = 6'(i);
    end
    nm_nxt.sign = sm_r.sign;
    nm_nxt.zero = (sm_r.mag == 64'd0);
    nm_nxt.msb  = p;
    nm_nxt.norm = sm_r.mag << (6'd63 - p);
  end

  always_comb begin
    logic [52:0] keep;
    logic [53:0] sum;
    logic [10:0] expo;
    logic guard, sticky, up;
    keep   = nm_r.norm[63:11];
    guard  = nm_r.norm[10];
    sticky = |nm_r.norm[9:0];
    up     = guard & (sticky | keep[0]);
    sum    = {1'b0, keep} + 54'(up);
    expo   = EXP_BIAS + 11'(nm_r.msb);
    // carry out of rounding bumps the exponent, fraction is then zero
    if (sum[53]) expo = expo + 11'd1;
    res_nxt = nm_r.zero ? 64'd0 : {nm_r.sign, expo, sum[51:0]};
  end

  always_ff @(posedge clk) begin
    if (en[0]) sm_r <= sm_nxt;
    if (en[1]) nm_r <= nm_nxt;
    if (en[2]) res_r <= res_nxt;
  end

  assign result = res_r;
endmodule
`default_nettype wire

>>> rtl/i2d_ctrl.sv
// stage valid bits and stall control for the three-step pipeline
`default_nettype none
module i2d_ctrl (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      en
);
  logic [2:0] vld_r, vld_nxt;
  logic [2:0] adv;

  always_comb begin
    adv[2] = !vld_r[2] || out_ready;
    adv[1] = !vld_r[1] || adv[2];
    adv[0] = !vld_r[0] || adv[1];
    en[0] = adv[0] && in_valid;
    en[1] = adv[1] && vld_r[0];
    en[2] = adv[2] && vld_r[1];
    vld_nxt[0] = adv[0] ? in_valid : vld_r[0];
    vld_nxt[1] = adv[1] ? vld_r[0] : vld_r[1];
    vld_nxt[2] = adv[2] ? vld_r[1] : vld_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= vld_nxt;
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[2];
endmodule
`default_nettype wire

>>> rtl/int64_to_double_convert.sv
// Converts LANES 64-bit integers per item (signed or unsigned by kind) to
// binary64 patterns rounded to nearest even. One item is accepted every
// cycle while the output is not stalled; each lane is a three-stage pipeline
// (magnitude, leading-one normalize, round and pack). Zero gives +0.
`default_nettype none
module int64_to_double_convert import i2d_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  i2d_if.sink      in_ch,
  i2d_if.source    out_ch
);
  logic [2:0] en;
  logic is_signed;

  i2d_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .en(en)
  );

  assign is_signed = (in_ch.data.kind == KIND_SIGNED);

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    i2d_lane u_lane (
      .clk(clk), .en(en), .is_signed(is_signed),
      .raw(in_ch.data.values[g]), .result(out_ch.data.doubles[g])
    );
  end
endmodule
`default_nettype wire

>>> rtl/i2d_checker.sv
// port-level checks on the converter, bound to the top level
`default_nettype none
module i2d_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [63:0] out_d0
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("out valid dropped");
  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_d0)) else $error("out data moved");
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("stalled with empty output");
  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result right after reset");
  a_no_input_x: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown(in_valid)) else $error("input valid unknown");
endmodule

bind int64_to_double_convert i2d_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_d0(out_ch.data.doubles[0])
);
`default_nettype wire
